// ----- rtl/downlink_mac_command_parser_top_assert.svh -----
// assertion macros for the downlink mac command parser
`ifndef DOWNLINK_MAC_COMMAND_PARSER_TOP_ASSERT_SVH
`define DOWNLINK_MAC_COMMAND_PARSER_TOP_ASSERT_SVH

`ifndef SYNTHESIS
// antecedent holds now, consequent must hold in the same cycle
`define DMCP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dmcp assertion failed");
// antecedent holds now, consequent must hold in the next cycle
`define DMCP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dmcp assertion failed");
`else
`define DMCP_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define DMCP_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ----- rtl/dmcp_pkg.sv -----
`default_nettype none

package dmcp_pkg;

    // command codes
    localparam logic [3:0] CMD_LINKCHECK = 4'd0;
    localparam logic [3:0] CMD_LINKADR   = 4'd1;
    localparam logic [3:0] CMD_DUTY      = 4'd2;
    localparam logic [3:0] CMD_RXPARAM   = 4'd3;
    localparam logic [3:0] CMD_DEVSTATUS = 4'd4;
    localparam logic [3:0] CMD_NEWCHAN   = 4'd5;
    localparam logic [3:0] CMD_DLCHAN    = 4'd6;
    localparam logic [3:0] CMD_RXTIMING  = 4'd7;
    localparam logic [3:0] CMD_TXPARAM   = 4'd8;
    localparam logic [3:0] CMD_CLASSB0   = 4'd9;
    localparam logic [3:0] CMD_CLASSB1   = 4'd10;
    localparam logic [3:0] CMD_CLASSB2   = 4'd11;
    localparam logic [3:0] CMD_CLASSB3   = 4'd12;

    // record status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_UNKNOWN = 2'd1;
    localparam logic [1:0] ST_TRUNC   = 2'd2;

    // tag byte values
    localparam logic [7:0] TAG_LINKCHECK = 8'h02;
    localparam logic [7:0] TAG_LINKADR   = 8'h03;
    localparam logic [7:0] TAG_DUTY      = 8'h04;
    localparam logic [7:0] TAG_RXPARAM   = 8'h05;
    localparam logic [7:0] TAG_DEVSTATUS = 8'h06;
    localparam logic [7:0] TAG_NEWCHAN   = 8'h07;
    localparam logic [7:0] TAG_RXTIMING  = 8'h08;
    localparam logic [7:0] TAG_TXPARAM   = 8'h09;
    localparam logic [7:0] TAG_DLCHAN    = 8'h0A;
    localparam logic [7:0] TAG_CLASSB0   = 8'h10;
    localparam logic [7:0] TAG_CLASSB1   = 8'h11;
    localparam logic [7:0] TAG_CLASSB2   = 8'h12;
    localparam logic [7:0] TAG_CLASSB3   = 8'h13;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_buffer;
    } cmd_byte_t;

    typedef struct packed {
        logic [3:0]  command;
        logic [1:0]  status;
        logic [3:0]  high_nibble;
        logic [3:0]  low_nibble;
        logic [2:0]  mask_control;
        logic [3:0]  repetitions;
        logic [15:0] channel_mask;
        logic [7:0]  channel_index;
        logic [23:0] frequency;
        logic [7:0]  link_margin;
        logic [7:0]  gateway_count;
        logic [1:0]  dwell_flags;
    } cmd_rec_t;

    // parse state; bytes_seen zero with discarding clear means a tag is expected
    typedef struct packed {
        logic [3:0]  cur_cmd;
        logic [2:0]  bytes_seen;
        logic        discarding;
        logic [7:0]  first_byte;
        logic [15:0] mask_acc;
        logic [23:0] freq_acc;
    } parse_state_t;

    typedef struct packed {
        logic       known;
        logic [3:0] cmd;
    } tag_hit_t;

    function automatic tag_hit_t tag_lookup(input logic [7:0] tag);
        tag_hit_t hit;
        hit.known = 1'b1;
        case (tag)
            TAG_LINKCHECK: hit.cmd = CMD_LINKCHECK;
            TAG_LINKADR:   hit.cmd = CMD_LINKADR;
            TAG_DUTY:      hit.cmd = CMD_DUTY;
            TAG_RXPARAM:   hit.cmd = CMD_RXPARAM;
            TAG_DEVSTATUS: hit.cmd = CMD_DEVSTATUS;
            TAG_NEWCHAN:   hit.cmd = CMD_NEWCHAN;
            TAG_RXTIMING:  hit.cmd = CMD_RXTIMING;
            TAG_TXPARAM:   hit.cmd = CMD_TXPARAM;
            TAG_DLCHAN:    hit.cmd = CMD_DLCHAN;
            TAG_CLASSB0:   hit.cmd = CMD_CLASSB0;
            TAG_CLASSB1:   hit.cmd = CMD_CLASSB1;
            TAG_CLASSB2:   hit.cmd = CMD_CLASSB2;
            TAG_CLASSB3:   hit.cmd = CMD_CLASSB3;
            default:
            begin
                hit.known = 1'b0;
                hit.cmd   = CMD_LINKCHECK;
            end
        endcase
        return hit;
    endfunction

    function automatic logic [2:0] payload_len(input logic [3:0] cmd);
        logic [2:0] len;
        case (cmd)
            CMD_LINKCHECK: len = 3'd2;
            CMD_LINKADR:   len = 3'd4;
            CMD_DUTY:      len = 3'd1;
            CMD_RXPARAM:   len = 3'd4;
            CMD_DEVSTATUS: len = 3'd0;
            CMD_NEWCHAN:   len = 3'd5;
            CMD_DLCHAN:    len = 3'd4;
            CMD_RXTIMING:  len = 3'd1;
            CMD_TXPARAM:   len = 3'd1;
            CMD_CLASSB0:   len = 3'd2;
            CMD_CLASSB1:   len = 3'd2;
            CMD_CLASSB2:   len = 3'd2;
            CMD_CLASSB3:   len = 3'd2;
            default:       len = 3'd0;
        endcase
        return len;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/downlink_mac_command_parser_top.sv -----
// downlink mac command parser: one command byte per transaction, one record per command
// a record is registered and appears in the cycle after the byte that completes or ends its command
// throughput: one byte every cycle while no finished record is held by a stalled output
// the input stalls only while a finished record is held by a stalled output
// reset (rst_n low, asynchronous): parser expects a tag, nothing discarded, no record held
`default_nettype none

`include "downlink_mac_command_parser_top_assert.svh"

module downlink_mac_command_parser_top
    import dmcp_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    // command byte channel
    input  wire logic      cmd_valid,
    output logic           cmd_stall,
    input  wire cmd_byte_t cmd_data,
    // decoded record channel
    output logic           rec_valid,
    input  wire logic      rec_stall,
    output cmd_rec_t       rec_data
);

    parse_state_t st_reg;
    parse_state_t st_next;
    logic         rec_valid_reg;
    logic         rec_valid_next;
    cmd_rec_t     rec_data_reg;
    cmd_rec_t     dec_rec;
    logic         dec_hit;
    logic         take;
    logic         hold;

    // record register is busy when it holds a record the sink is not taking
    assign hold      = rec_valid_reg && rec_stall;
    assign cmd_stall = hold;
    assign take      = cmd_valid && !hold;

    // next parse state and record from the current state and the byte
    dmcp_decode u_decode (
        .st      (st_reg),
        .item    (cmd_data),
        .st_next (st_next),
        .rec_hit (dec_hit),
        .rec     (dec_rec)
    );

    // a held record stays; otherwise the register takes whatever this byte produced
    assign rec_valid_next = hold || (take && dec_hit);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= '0;
            rec_valid_reg <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                st_reg <= st_next;
            end
            rec_valid_reg <= rec_valid_next;
        end
    end

    // record payload, loaded only when a new record is produced
    always_ff @(posedge clk)
    begin
        if (take && dec_hit)
        begin
            rec_data_reg <= dec_rec;
        end
    end

    assign rec_valid = rec_valid_reg;
    assign rec_data  = rec_data_reg;

    // bytes dropped after an unknown tag never produce a record
    `DMCP_ASSERT_NEXT(a_discard_silent, clk, rst_n,
        take && st_reg.discarding, !rec_valid)
    // a marked byte always returns the parser to expecting a tag
    `DMCP_ASSERT_NEXT(a_eob_idle, clk, rst_n,
        take && cmd_data.end_of_buffer, (st_reg.bytes_seen == 3'd0) && !st_reg.discarding)
    // the byte counter never runs past the current command's payload
    `DMCP_ASSERT_NOW(a_count_bound, clk, rst_n,
        st_reg.bytes_seen != 3'd0,
        (st_reg.bytes_seen <= payload_len(st_reg.cur_cmd)) && !st_reg.discarding)

endmodule

`default_nettype wire

// ----- rtl/dmcp_decode.sv -----
`default_nettype none

module dmcp_decode
    import dmcp_pkg::*;
(
    input  parse_state_t st,
    input  cmd_byte_t    item,
    output parse_state_t st_next,
    output logic         rec_hit,
    output cmd_rec_t     rec
);

    // split a completed command into its record fields
    function automatic cmd_rec_t decoded(
        input logic [3:0]  cmd,
        input logic [7:0]  last,
        input logic [7:0]  first,
        input logic [15:0] mask,
        input logic [23:0] freq
    );
        cmd_rec_t r;
        r = '0;
        r.command = cmd;
        r.status  = ST_OK;
        case (cmd)
            CMD_LINKADR:
            begin
                r.high_nibble  = first[7:4];
                r.low_nibble   = first[3:0];
                r.mask_control = last[6:4];
                r.repetitions  = last[3:0];
                r.channel_mask = mask;
            end
            CMD_DUTY, CMD_RXTIMING:
            begin
                r.low_nibble = last[3:0];
            end
            CMD_RXPARAM:
            begin
                r.high_nibble = {1'b0, first[6:4]};
                r.low_nibble  = first[3:0];
                r.frequency   = freq | {last, 16'h0000};
            end
            CMD_DEVSTATUS:
            begin
                r.command = cmd;
            end
            CMD_NEWCHAN:
            begin
                r.high_nibble   = last[7:4];
                r.low_nibble    = last[3:0];
                r.channel_index = first;
                r.frequency     = freq;
            end
            CMD_DLCHAN:
            begin
                r.channel_index = first;
                r.frequency     = freq | {last, 16'h0000};
            end
            CMD_TXPARAM:
            begin
                r.low_nibble  = last[3:0];
                r.dwell_flags = {last[5], last[4]};
            end
            default:
            begin
                // linkcheck answer layout, also used by class b tags
                r.link_margin   = first;
                r.gateway_count = last;
            end
        endcase
        return r;
    endfunction

    tag_hit_t   hit;
    logic [2:0] tag_len;
    logic [2:0] cur_len;
    logic [2:0] pos;
    logic       last_byte;

    assign hit       = tag_lookup(item.data_byte);
    assign tag_len   = payload_len(hit.cmd);
    assign cur_len   = payload_len(st.cur_cmd);
    assign pos       = st.bytes_seen - 3'd1;
    assign last_byte = ({1'b0, pos} + 4'd1) >= {1'b0, cur_len};

    always_comb
    begin
        st_next = st;
        rec_hit = 1'b0;
        rec     = '0;
        if (st.discarding)
        begin
            if (item.end_of_buffer)
            begin
                st_next = '0;
            end
        end
        else if (st.bytes_seen == 3'd0)
        begin
            if (!hit.known)
            begin
                rec_hit            = 1'b1;
                rec.status         = ST_UNKNOWN;
                st_next            = '0;
                st_next.discarding = !item.end_of_buffer;
            end
            else if (tag_len == 3'd0)
            begin
                rec_hit = 1'b1;
                rec     = decoded(hit.cmd, item.data_byte, 8'h00, 16'h0000, 24'h000000);
                st_next = '0;
            end
            else if (item.end_of_buffer)
            begin
                rec_hit     = 1'b1;
                rec.command = hit.cmd;
                rec.status  = ST_TRUNC;
                st_next     = '0;
            end
            else
            begin
                st_next            = '0;
                st_next.cur_cmd    = hit.cmd;
                st_next.bytes_seen = 3'd1;
            end
        end
        else if (last_byte)
        begin
            rec_hit = 1'b1;
            rec     = decoded(st.cur_cmd, item.data_byte, st.first_byte,
                              st.mask_acc, st.freq_acc);
            st_next = '0;
        end
        else
        begin
            case (pos)
                3'd0: st_next.first_byte = item.data_byte;
                3'd1:
                begin
                    st_next.mask_acc[7:0] = item.data_byte;
                    st_next.freq_acc[7:0] = item.data_byte;
                end
                3'd2:
                begin
                    st_next.mask_acc[15:8] = item.data_byte;
                    st_next.freq_acc[15:8] = item.data_byte;
                end
                3'd3: st_next.freq_acc[23:16] = item.data_byte;
                default: st_next.first_byte = st.first_byte;
            endcase
            if (item.end_of_buffer)
            begin
                rec_hit     = 1'b1;
                rec.command = st.cur_cmd;
                rec.status  = ST_TRUNC;
                st_next     = '0;
            end
            else
            begin
                st_next.bytes_seen = st.bytes_seen + 3'd1;
            end
        end
    end

endmodule

`default_nettype wire
